### design/hse_pkg.sv
`default_nettype none

package hse_pkg;

    localparam int HSE_DEPTH      = 64;
    localparam int HSE_DATA_WIDTH = 32;

    localparam int VALUE_W = 32;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam int REG_DESC   = 0;
    localparam int REG_SIGNED = 1;

    typedef struct packed {
        logic desc;
        logic sgn;
    } t_cfg;

endpackage

`default_nettype wire

### design/hse_ifs.sv
`default_nettype none

interface hse_in_if import hse_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] data_value;
    logic               last_item;

    modport source (output valid, data_value, last_item, input ready);
    modport sink (input valid, data_value, last_item, output ready);
endinterface

interface hse_out_if import hse_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] sorted_value;
    logic               final_result;
    logic               overflowed;

    modport source (output valid, sorted_value, final_result, overflowed, input ready);
    modport sink (input valid, sorted_value, final_result, overflowed, output ready);
endinterface

`default_nettype wire

### design/hse_ram.sv
`default_nettype none

module hse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

`default_nettype wire

### design/heap_sort_engine_top.sv
// heap sort engine
//
// i_req takes one element per request; last_item closes the set. Up to
// DEPTH elements are kept; further ones are dropped and every result of
// that run carries overflowed = 1. o_res returns the set in ascending or
// descending order (register 0 at paddr 0), compared unsigned or signed
// (register 1 at paddr 4), with final_result on the last one.
//
// Loading accepts one element per cycle. After the closing request the heap
// is built and sorted in one 2-read/1-write memory: each sift-down first
// reads and loads the held element, then moves the winning child up for
// each level it descends and finally writes back the held element. Results
// then leave from the same memory, each one read and placed in the output
// register before the next is read. A single element goes straight to
// output. i_req.ready is high only while loading; the next set may start as
// soon as the last result sits in the output register.
//
// A stall on o_res holds the output register and the emit sequence.
// Reset empties the set, clears the overflow flag and both registers; no
// memory clearing pass is needed.
`default_nettype none

module heap_sort_engine_top import hse_pkg::*; #(
    parameter int DEPTH      = HSE_DEPTH,
    parameter int DATA_WIDTH = HSE_DATA_WIDTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    hse_in_if.sink                  i_req,
    hse_out_if.source               o_res,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    localparam int DW = DATA_WIDTH;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int NW = CW + 1;
    localparam logic [DW-1:0] SIGN_MSK = DW'(1) << (DW - 1);

    localparam logic [2:0] ST_LOAD    = 3'd0;
    localparam logic [2:0] ST_BLD_RD  = 3'd1;
    localparam logic [2:0] ST_BLD_LD  = 3'd2;
    localparam logic [2:0] ST_SIFT    = 3'd3;
    localparam logic [2:0] ST_EXT_RD  = 3'd4;
    localparam logic [2:0] ST_EXT_LD  = 3'd5;
    localparam logic [2:0] ST_EMIT_RD = 3'd6;
    localparam logic [2:0] ST_EMIT_WR = 3'd7;

    function automatic logic f_above(input logic [DW-1:0] x, input logic [DW-1:0] y,
                                     input t_cfg cfg);
        logic [DW-1:0] kx;
        logic [DW-1:0] ky;
        kx = cfg.sgn ? (x ^ SIGN_MSK) : x;
        ky = cfg.sgn ? (y ^ SIGN_MSK) : y;
        return cfg.desc ? (kx < ky) : (kx > ky);
    endfunction

    // control state
    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic          r_extract, n_extract;
    logic [AW-1:0] r_i, n_i;
    logic [AW-1:0] r_node, n_node;
    logic [CW-1:0] r_size, n_size;
    logic [AW-1:0] r_k, n_k;
    logic          r_out_valid, n_out_valid;
    t_cfg          r_cfg;

    // payload
    logic [DW-1:0]      r_cur, n_cur;
    logic [VALUE_W-1:0] r_out_value, n_out_value;
    logic               r_out_final, n_out_final;
    logic               r_out_ovf, n_out_ovf;

    // memory ports
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [DW-1:0] w_wdata;
    logic          w_re;
    logic [AW-1:0] w_raddr_a;
    logic [AW-1:0] w_raddr_b;
    logic [DW-1:0] w_rd_a;
    logic [DW-1:0] w_rd_b;

    logic [DW-1:0]      w_in_val;
    logic [VALUE_W-1:0] w_out_val;
    logic               w_in_acc;
    logic               w_out_free;
    logic               w_cfg_wr;
    logic               w_reg_idx;

    logic [NW-1:0] w_s_left;
    logic [NW-1:0] w_s_right;
    logic          w_take_l;
    logic          w_take_r;
    logic [DW-1:0] w_cand_v;
    logic [AW-1:0] w_cand_i;
    logic [DW-1:0] w_best_v;
    logic [AW-1:0] w_best_i;
    logic          w_sift_done;
    logic [AW-1:0] w_c_node;
    logic [NW-1:0] w_c_left;
    logic [NW-1:0] w_c_right;
    logic [CW-1:0] w_new_count;
    logic          w_emit_last;

    hse_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_re      (w_re),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_rd_a),
        .o_rdata_b (w_rd_b)
    );

    generate
        if (DW <= VALUE_W) begin : g_in_narrow
            assign w_in_val = i_req.data_value[DW-1:0];
        end else begin : g_in_wide
            assign w_in_val = {{(DW - VALUE_W){1'b0}}, i_req.data_value};
        end
        if (DW >= VALUE_W) begin : g_out_narrow
            assign w_out_val = w_rd_a[VALUE_W-1:0];
        end else begin : g_out_wide
            assign w_out_val = {{(VALUE_W - DW){1'b0}}, w_rd_a};
        end
    endgenerate

    // configuration port
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = paddr[2];

    always_comb begin
        prdata = '0;
        case (w_reg_idx)
            1'(REG_DESC):   prdata[0] = r_cfg.desc;
            1'(REG_SIGNED): prdata[0] = r_cfg.sgn;
            default:        prdata    = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                1'(REG_DESC):   r_cfg.desc <= pwdata[0];
                1'(REG_SIGNED): r_cfg.sgn  <= pwdata[0];
                default:        r_cfg      <= r_cfg;
            endcase
        end
    end

    // handshakes
    assign i_req.ready        = (r_state == ST_LOAD);
    assign w_in_acc           = i_req.valid && i_req.ready;
    assign w_out_free         = !r_out_valid || o_res.ready;
    assign o_res.valid        = r_out_valid;
    assign o_res.sorted_value = r_out_value;
    assign o_res.final_result = r_out_final;
    assign o_res.overflowed   = r_out_ovf;

    // sift-down compare: hole at r_node holds r_cur, children come from memory
    assign w_s_left    = NW'({r_node, 1'b1});
    assign w_s_right   = w_s_left + NW'(1);
    assign w_take_l    = (w_s_left < NW'(r_size)) && f_above(w_rd_a, r_cur, r_cfg);
    assign w_cand_v    = w_take_l ? w_rd_a : r_cur;
    assign w_cand_i    = w_take_l ? w_s_left[AW-1:0] : r_node;
    assign w_take_r    = (w_s_right < NW'(r_size)) && f_above(w_rd_b, w_cand_v, r_cfg);
    assign w_best_v    = w_take_r ? w_rd_b : w_cand_v;
    assign w_best_i    = w_take_r ? w_s_right[AW-1:0] : w_cand_i;
    assign w_sift_done = !w_take_l && !w_take_r;

    assign w_new_count = (r_count < CW'(DEPTH)) ? r_count + CW'(1) : r_count;
    assign w_emit_last = (NW'(r_k) == NW'(r_count) - NW'(1));

    always_comb begin
        case (r_state)
            ST_BLD_LD: w_c_node = r_i;
            ST_SIFT:   w_c_node = w_best_i;
            default:   w_c_node = '0;
        endcase
    end
    assign w_c_left  = NW'({w_c_node, 1'b1});
    assign w_c_right = w_c_left + NW'(1);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_extract   = r_extract;
        n_i         = r_i;
        n_node      = r_node;
        n_size      = r_size;
        n_k         = r_k;
        n_out_valid = r_out_valid && !o_res.ready;
        n_cur       = r_cur;
        n_out_value = r_out_value;
        n_out_final = r_out_final;
        n_out_ovf   = r_out_ovf;
        w_we        = 1'b0;
        w_waddr     = r_node;
        w_wdata     = r_cur;
        w_re        = 1'b0;
        w_raddr_a   = w_c_left[AW-1:0];
        w_raddr_b   = w_c_right[AW-1:0];

        case (r_state)
            ST_LOAD: begin
                if (w_in_acc) begin
                    if (r_count < CW'(DEPTH)) begin
                        w_we    = 1'b1;
                        w_waddr = r_count[AW-1:0];
                        w_wdata = w_in_val;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    n_count = w_new_count;
                    if (i_req.last_item) begin
                        n_k       = '0;
                        n_extract = 1'b0;
                        n_i       = AW'((w_new_count - CW'(2)) >> 1);
                        n_state   = (w_new_count == CW'(1)) ? ST_EMIT_RD : ST_BLD_RD;
                    end
                end
            end
            ST_BLD_RD: begin
                w_re      = 1'b1;
                w_raddr_a = r_i;
                n_state   = ST_BLD_LD;
            end
            ST_BLD_LD: begin
                w_re    = 1'b1;
                n_cur   = w_rd_a;
                n_node  = r_i;
                n_size  = r_count;
                n_state = ST_SIFT;
            end
            ST_SIFT: begin
                w_we    = 1'b1;
                w_waddr = r_node;
                if (w_sift_done) begin
                    w_wdata = r_cur;
                    if (!r_extract) begin
                        if (r_i == '0) begin
                            n_extract = 1'b1;
                            n_i       = AW'(r_count - CW'(1));
                            n_state   = ST_EXT_RD;
                        end else begin
                            n_i     = r_i - AW'(1);
                            n_state = ST_BLD_RD;
                        end
                    end else if (r_i == AW'(1)) begin
                        n_k     = '0;
                        n_state = ST_EMIT_RD;
                    end else begin
                        n_i     = r_i - AW'(1);
                        n_state = ST_EXT_RD;
                    end
                end else begin
                    w_wdata = w_best_v;
                    w_re    = 1'b1;
                    n_node  = w_best_i;
                end
            end
            ST_EXT_RD: begin
                w_re      = 1'b1;
                w_raddr_a = '0;
                w_raddr_b = r_i;
                n_state   = ST_EXT_LD;
            end
            ST_EXT_LD: begin
                // old root moves to the end, the end element sifts from the root
                w_we    = 1'b1;
                w_waddr = r_i;
                w_wdata = w_rd_a;
                w_re    = 1'b1;
                n_cur   = w_rd_b;
                n_node  = '0;
                n_size  = CW'(r_i);
                n_state = ST_SIFT;
            end
            ST_EMIT_RD: begin
                w_re      = 1'b1;
                w_raddr_a = r_k;
                n_state   = ST_EMIT_WR;
            end
            ST_EMIT_WR: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_value = w_out_val;
                    n_out_final = w_emit_last;
                    n_out_ovf   = r_ovf;
                    if (w_emit_last) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = ST_LOAD;
                    end else begin
                        n_k     = r_k + AW'(1);
                        n_state = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_extract   <= 1'b0;
            r_i         <= '0;
            r_node      <= '0;
            r_size      <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_extract   <= n_extract;
            r_i         <= n_i;
            r_node      <= n_node;
            r_size      <= n_size;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur       <= n_cur;
        r_out_value <= n_out_value;
        r_out_final <= n_out_final;
        r_out_ovf   <= n_out_ovf;
    end

`ifndef SYNTHESIS
    a_drop_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && r_count == CW'(DEPTH) && !i_req.last_item) |=> r_ovf)
        else $error("dropped element did not set overflow flag");

    a_node_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SIFT) |-> (CW'(r_node) < r_size && r_size <= r_count))
        else $error("sift node outside heap");

    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT_WR && w_out_free && w_emit_last)
        |=> (r_state == ST_LOAD && r_count == '0 && !r_ovf && r_out_final))
        else $error("run did not close after final result");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= CW'(DEPTH)))
        else $error("element count beyond capacity");

    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_LOAD) |-> !i_req.ready)
        else $error("request taken while sorting");
`endif

endmodule

`default_nettype wire

### tb/sv/heap_sort_engine_top_test.sv
`default_nettype none

module heap_sort_engine_top_test import hse_pkg::*;;

    localparam int CYCLE_LIMIT  = 400_000;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 8;
    localparam int TAIL_CYCLES  = 40;
    localparam int PHASE_ITEMS  = 28;
    localparam int DIR_ROWS     = 23;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last_flag;
        logic               ovf_flag;
    } t_sorted_result;

    typedef struct {
        logic               desc;
        logic               sgn;
        logic [VALUE_W-1:0] value;
        int                 reps;
        logic [VALUE_W-1:0] stride;
        logic               close;
        bit                 typed;
        logic [VALUE_W-1:0] exp_value;
        logic               exp_last;
        logic               exp_ovf;
    } t_directed_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    wire  [PDATA_W-1:0] prdata;
    wire                pready;

    hse_in_if  req_if ();
    hse_out_if res_if ();

    heap_sort_engine_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // sorter state as seen from outside
    logic [VALUE_W-1:0] load_store [HSE_DEPTH];
    int unsigned        load_count = 0;
    bit                 load_dropped = 1'b0;
    bit                 order_desc = 1'b0;
    bit                 order_signed = 1'b0;

    t_sorted_result expected_sorted [$];
    t_sorted_result run_results [$];
    t_sorted_result got_result;
    t_sorted_result want_result;

    int mismatch_count = 0;
    int cycle_count = 0;
    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int hold_orders = 0;
    int hold_taken = 0;
    int hold_left = 0;

    t_directed_row dir_rows [DIR_ROWS] = '{
        '{1'b0, 1'b0, 32'h0000_0000, 1, 32'h0, 1'b1, 1'b1, 32'h0000_0000, 1'b1, 1'b0},
        '{1'b0, 1'b0, 32'hFFFF_FFFF, 1, 32'h0, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0},
        '{1'b0, 1'b0, 32'h8000_0000, 1, 32'h0, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
        '{1'b0, 1'b0, 32'h0000_0001, 1, 32'h0, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
        '{1'b0, 1'b0, 32'hFFFF_FFFF, 1, 32'h0, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
        '{1'b0, 1'b0, 32'h7FFF_FFFF, 1, 32'h0, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0},
        '{1'b0, 1'b1, 32'h8000_0000, 1, 32'h0, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
        '{1'b0, 1'b1, 32'h0000_0001, 1, 32'h0, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
        '{1'b0, 1'b1, 32'hFFFF_FFFF, 1, 32'h0, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
        '{1'b0, 1'b1, 32'h7FFF_FFFF, 1, 32'h0, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0},
        '{1'b1, 1'b0, 32'h8000_0000, 1, 32'h0, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
        '{1'b1, 1'b0, 32'h0000_0001, 1, 32'h0, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
        '{1'b1, 1'b0, 32'hFFFF_FFFF, 1, 32'h0, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
        '{1'b1, 1'b0, 32'h7FFF_FFFF, 1, 32'h0, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0},
        '{1'b1, 1'b1, 32'h8000_0000, 1, 32'h0, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
        '{1'b1, 1'b1, 32'h0000_0001, 1, 32'h0, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
        '{1'b1, 1'b1, 32'hFFFF_FFFF, 1, 32'h0, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
        '{1'b1, 1'b1, 32'h7FFF_FFFF, 1, 32'h0, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0},
        // equal values
        '{1'b1, 1'b1, 32'hA5A5_A5A5, 3, 32'h0, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0},
        // store full, closing request dropped
        '{1'b0, 1'b1, 32'hFFFF_FFE0, 65, 32'h1, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0},
        // overflow flag cleared for the next set
        '{1'b0, 1'b1, 32'h5A5A_5A5A, 1, 32'h0, 1'b1, 1'b1, 32'h5A5A_5A5A, 1'b1, 1'b0},
        '{1'b0, 1'b0, 32'hDEAD_BEEF, 1, 32'h0, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
        '{1'b0, 1'b0, 32'h1234_5678, 1, 32'h0, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0}
    };

    function automatic bit sorts_ahead(input logic [VALUE_W-1:0] a, input logic [VALUE_W-1:0] b);
        logic [VALUE_W-1:0] ka;
        logic [VALUE_W-1:0] kb;
        ka = order_signed ? a ^ 32'h8000_0000 : a;
        kb = order_signed ? b ^ 32'h8000_0000 : b;
        return order_desc ? (ka > kb) : (ka < kb);
    endfunction

    function automatic void load_element(input logic [VALUE_W-1:0] v, input logic close);
        logic [VALUE_W-1:0] run [$];
        logic [VALUE_W-1:0] tmp;
        int j;
        if (load_count < HSE_DEPTH) begin
            load_store[load_count] = v;
            load_count++;
        end else begin
            load_dropped = 1'b1;
        end
        if (!close) return;
        for (int i = 0; i < load_count; i++) run.push_back(load_store[i]);
        for (int i = 1; i < run.size(); i++) begin
            j = i;
            while (j > 0 && sorts_ahead(run[j], run[j-1])) begin
                tmp = run[j];
                run[j] = run[j-1];
                run[j-1] = tmp;
                j--;
            end
        end
        for (int k = 0; k < run.size(); k++) begin
            run_results.push_back('{run[k], k == run.size() - 1, load_dropped});
        end
        load_count = 0;
        load_dropped = 1'b0;
    endfunction

    task automatic send_element(input logic [VALUE_W-1:0] v, input logic close,
                                input bit typed, input t_sorted_result typed_res);
        while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.data_value <= v;
        req_if.last_item  <= close;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        run_results.delete();
        load_element(v, close);
        if (typed && close) begin
            expected_sorted.push_back(typed_res);
        end else begin
            foreach (run_results[i]) expected_sorted.push_back(run_results[i]);
        end
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_sorted.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input int idx, input logic [PDATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx * 4);
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_config(input logic desc, input logic sgn);
        wait_drained();
        write_register(REG_DESC, PDATA_W'(desc));
        write_register(REG_SIGNED, PDATA_W'(sgn));
        order_desc   = desc;
        order_signed = sgn;
    endtask

    task automatic set_idle_mode(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin
                src_idle_pct  <= 0;
                snk_stall_pct <= 0;
            end
            IDLE_SENDER: begin
                src_idle_pct  <= 69;
                snk_stall_pct <= 0;
            end
            IDLE_RECEIVER: begin
                src_idle_pct  <= 0;
                snk_stall_pct <= 69;
            end
            default: begin
                src_idle_pct  <= 29;
                snk_stall_pct <= 29;
            end
        endcase
    endtask

    function automatic logic [VALUE_W-1:0] random_value();
        case ($urandom_range(3))
            0: return $urandom;
            1: return VALUE_W'($urandom_range(7));
            2: return 32'h7FFF_FFFC + VALUE_W'($urandom_range(7));
            default: begin
                case ($urandom_range(3))
                    0: return 32'h0000_0000;
                    1: return 32'hFFFF_FFFF;
                    2: return 32'h8000_0000;
                    default: return 32'h7FFF_FFFF;
                endcase
            end
        endcase
    endfunction

    function automatic int pick_set_size();
        int r;
        r = $urandom_range(99);
        if (r < 45) return $urandom_range(1, 4);
        if (r < 85) return $urandom_range(5, 16);
        if (r < 97) return $urandom_range(17, 40);
        return $urandom_range(HSE_DEPTH, HSE_DEPTH + 3);
    endfunction

    // receiver side with one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            res_if.ready <= 1'b0;
        end else if (hold_orders != hold_taken) begin
            hold_taken   <= hold_orders;
            hold_left    <= LONG_HOLD;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got_result = '{res_if.sorted_value, res_if.final_result, res_if.overflowed};
            if (expected_sorted.size() == 0) begin
                $display("%0t unexpected result: value %h final %b overflowed %b", $time,
                         got_result.value, got_result.last_flag, got_result.ovf_flag);
                mismatch_count++;
            end else begin
                want_result = expected_sorted.pop_front();
                if (got_result !== want_result) begin
                    $display("%0t mismatch: expected value %h final %b overflowed %b", $time,
                             want_result.value, want_result.last_flag, want_result.ovf_flag);
                    $display("%0t           actual   value %h final %b overflowed %b", $time,
                             got_result.value, got_result.last_flag, got_result.ovf_flag);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", expected_sorted.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        t_directed_row row;
        int            set_size;
        int            items_in_phase;

        req_if.valid      = 1'b0;
        req_if.data_value = '0;
        req_if.last_item  = 1'b0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            row = dir_rows[r];
            if (load_count == 0 && (row.desc != order_desc || row.sgn != order_signed)) begin
                apply_config(row.desc, row.sgn);
            end
            for (int k = 0; k < row.reps; k++) begin
                send_element(row.value + VALUE_W'(k) * row.stride,
                             row.close && k == row.reps - 1, row.typed,
                             '{row.exp_value, row.exp_last, row.exp_ovf});
            end
        end

        for (int phase = 0; phase < 8; phase++) begin
            apply_config(phase[1] ^ phase[2], phase[2]);
            set_idle_mode(t_idle_mode'(phase % 4));
            if (phase == 3) hold_orders <= hold_orders + 1;
            items_in_phase = 0;
            while (items_in_phase < PHASE_ITEMS) begin
                set_size = pick_set_size();
                if (items_in_phase == 0 && phase == 2) set_size = HSE_DEPTH;
                if (items_in_phase == 0 && phase == 5) set_size = HSE_DEPTH + 2;
                for (int k = 0; k < set_size; k++) begin
                    send_element(random_value(), k == set_size - 1, 1'b0, '0);
                end
                items_in_phase += set_size;
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
design/hse_pkg.sv
design/hse_ifs.sv
design/hse_ram.sv
design/heap_sort_engine_top.sv
tb/sv/heap_sort_engine_top_test.sv
